// ===== rtl/dq_pkg.sv =====
// Shared types and constants for the circular deque block.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package dq_pkg;

  localparam int DEPTH   = 8;
  localparam int DATA_W  = 32;
  localparam int OCC_W   = 4;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LEFT  = 2'd1,
    CELL_FROM_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_op_t;

  // Result of decoding one beat, handed from the controller to the top level.
  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] count;
    logic             take_rear;
    logic [IDX_W-1:0] rear_idx;
  } step_t;

endpackage

// ===== rtl/dq_if.sv =====
// Valid/ready channel interfaces for the deque request and response beats.
// Depends on dq_pkg for the action type and the data and occupancy widths.
interface dq_req_if;
  logic                        valid;
  logic                        ready;
  dq_pkg::action_t             action;
  logic signed [dq_pkg::DATA_W-1:0] push_value;

  modport source (output valid, action, push_value, input ready);
  modport sink   (input valid, action, push_value, output ready);
endinterface

interface dq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [dq_pkg::DATA_W-1:0] pop_value;
  logic [1:0]                       status;
  logic [dq_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, pop_value, status, occupancy, input ready);
  modport sink   (input valid, pop_value, status, occupancy, output ready);
endinterface

// ===== rtl/circular_deque_unit.sv =====
// Circular deque of DEPTH 32-bit entries with push/pop at both ends.
// Every request beat produces one registered response beat, carrying the
// status (ok, full or empty), the popped value (0 unless a pop succeeds) and
// the occupancy after the step. One request is accepted per cycle unless the
// response side stalls: cell 0 of the cell chain is always the front, so a
// front operation shifts every cell by one place, a rear push writes only the
// cell at the current count and a rear pop changes no cell. A request is taken
// whenever the response register is empty or being drained in the same cycle.
// Depends on dq_pkg, dq_if, dq_cell and dq_ctrl.
module circular_deque_unit (
  input logic     clk,
  input logic     rst,
  dq_req_if.sink  req,
  dq_rsp_if.source rsp
);

  logic [dq_pkg::DATA_W-1:0] vals [dq_pkg::DEPTH];
  dq_pkg::cell_op_t          cell_op [dq_pkg::DEPTH];
  dq_pkg::step_t             step;
  logic                      fire;
  logic [dq_pkg::DATA_W-1:0] popped;

  logic                      rsp_valid;
  logic [dq_pkg::DATA_W-1:0] rsp_value;
  dq_pkg::status_t           rsp_status;
  logic [dq_pkg::OCC_W-1:0]  rsp_occ;

  assign req.ready = !rsp_valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  dq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .action  (req.action),
    .cell_op (cell_op),
    .step    (step)
  );

  for (genvar i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
    logic [dq_pkg::DATA_W-1:0] left_val;
    logic [dq_pkg::DATA_W-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = req.push_value;
    end else begin : g_mid_l
      assign left_val = vals[i-1];
    end
    if (i == dq_pkg::DEPTH - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_mid_r
      assign right_val = vals[i+1];
    end
    dq_cell u_cell (
      .clk       (clk),
      .op        (cell_op[i]),
      .left_val  (left_val),
      .right_val (right_val),
      .load_val  (req.push_value),
      .val       (vals[i])
    );
  end

  always_comb begin
    popped = '0;
    if (step.status == dq_pkg::ST_OK &&
        (req.action == dq_pkg::ACT_POP_FRONT || req.action == dq_pkg::ACT_POP_REAR)) begin
      popped = step.take_rear ? vals[step.rear_idx] : vals[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_value  <= popped;
      rsp_status <= step.status;
      rsp_occ    <= dq_pkg::OCC_W'(step.count);
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.pop_value = rsp_value;
  assign rsp.status    = rsp_status;
  assign rsp.occupancy = rsp_occ;

endmodule

// ===== rtl/dq_cell.sv =====
// One storage cell of the deque chain: holds one entry and can take its
// left or right neighbor's entry or a new value. Depends on dq_pkg.
module dq_cell (
  input  logic                     clk,
  input  dq_pkg::cell_op_t         op,
  input  logic [dq_pkg::DATA_W-1:0] left_val,
  input  logic [dq_pkg::DATA_W-1:0] right_val,
  input  logic [dq_pkg::DATA_W-1:0] load_val,
  output logic [dq_pkg::DATA_W-1:0] val
);

  always_ff @(posedge clk) begin
    unique case (op)
      dq_pkg::CELL_HOLD:       val <= val;
      dq_pkg::CELL_FROM_LEFT:  val <= left_val;
      dq_pkg::CELL_FROM_RIGHT: val <= right_val;
      dq_pkg::CELL_LOAD:       val <= load_val;
      default:                 val <= val;
    endcase
  end

endmodule

// ===== rtl/dq_ctrl.sv =====
// Occupancy counter and per-beat decode for the deque: status, new count and
// the operation each cell performs. Depends on dq_pkg.
module dq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  dq_pkg::action_t        action,
  output dq_pkg::cell_op_t       cell_op [dq_pkg::DEPTH],
  output dq_pkg::step_t          step
);

  logic [dq_pkg::CNT_W-1:0] count;
  logic [dq_pkg::CNT_W-1:0] count_next;
  logic                     full;
  logic                     empty;
  logic                     ok;

  assign full  = (count == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign empty = (count == '0);

  always_comb begin
    step.status    = dq_pkg::ST_OK;
    step.take_rear = 1'b0;
    step.rear_idx  = dq_pkg::IDX_W'(count - dq_pkg::CNT_W'(1));
    count_next     = count;
    unique case (action) inside
      dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_REAR: begin
        if (full) begin
          step.status = dq_pkg::ST_FULL;
        end else begin
          count_next = count + dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_REAR: begin
        if (empty) begin
          step.status = dq_pkg::ST_EMPTY;
        end else begin
          count_next     = count - dq_pkg::CNT_W'(1);
          step.take_rear = (action == dq_pkg::ACT_POP_REAR);
        end
      end
      default: count_next = count;
    endcase
    step.count = count_next;
  end

  assign ok = fire && (step.status == dq_pkg::ST_OK);

  // Front operations shift the whole chain; a rear push writes the first free cell.
  always_comb begin
    for (int i = 0; i < dq_pkg::DEPTH; i++) begin
      cell_op[i] = dq_pkg::CELL_HOLD;
      if (ok) begin
        unique case (action)
          dq_pkg::ACT_PUSH_FRONT: cell_op[i] = dq_pkg::CELL_FROM_LEFT;
          dq_pkg::ACT_PUSH_REAR: begin
            if (count == dq_pkg::CNT_W'(i)) begin
              cell_op[i] = dq_pkg::CELL_LOAD;
            end
          end
          dq_pkg::ACT_POP_FRONT:  cell_op[i] = dq_pkg::CELL_FROM_RIGHT;
          dq_pkg::ACT_POP_REAR:   cell_op[i] = dq_pkg::CELL_HOLD;
          default:                cell_op[i] = dq_pkg::CELL_HOLD;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

endmodule

// ===== sim/deque_checker.sv =====
// Scoreboard for the circular deque: watches both channels, predicts each response beat
// and compares it field by field. Depends on dq_pkg for the types, widths and depth.
module deque_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic                      req_ready,
  input  dq_pkg::action_t           req_action,
  input  logic [dq_pkg::DATA_W-1:0] req_push_value,
  input  logic                      rsp_valid,
  input  logic                      rsp_ready,
  input  logic [dq_pkg::DATA_W-1:0] rsp_pop_value,
  input  logic [1:0]                rsp_status,
  input  logic [dq_pkg::OCC_W-1:0]  rsp_occupancy,
  output int                        fail_count,
  output int                        pending,
  output int                        ok_count,
  output int                        full_count,
  output int                        empty_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [dq_pkg::DATA_W-1:0] pop_value;
    dq_pkg::status_t           status;
    logic [dq_pkg::OCC_W-1:0]  occupancy;
  } deque_result_t;

  logic [dq_pkg::DATA_W-1:0] store [dq_pkg::DEPTH];
  int front_idx;
  int back_idx;
  int fill;
  int errors;
  int n_ok;
  int n_full;
  int n_empty;
  deque_result_t expected_results[$];

  // back_idx points one slot past the rear entry, the next place a rear push lands.
  function automatic deque_result_t apply_request(dq_pkg::action_t act,
                                                  logic [dq_pkg::DATA_W-1:0] val);
    deque_result_t res;
    res.pop_value = '0;
    res.status    = dq_pkg::ST_OK;
    case (act) inside
      dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_REAR: begin
        if (fill >= dq_pkg::DEPTH) begin
          res.status = dq_pkg::ST_FULL;
        end else if (act == dq_pkg::ACT_PUSH_FRONT) begin
          front_idx = (front_idx + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
          store[front_idx] = val;
          fill++;
        end else begin
          store[back_idx] = val;
          back_idx = (back_idx + 1) % dq_pkg::DEPTH;
          fill++;
        end
      end
      default: begin
        if (fill == 0) begin
          res.status = dq_pkg::ST_EMPTY;
        end else if (act == dq_pkg::ACT_POP_FRONT) begin
          res.pop_value = store[front_idx];
          front_idx = (front_idx + 1) % dq_pkg::DEPTH;
          fill--;
        end else begin
          back_idx = (back_idx + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
          res.pop_value = store[back_idx];
          fill--;
        end
      end
    endcase
    res.occupancy = fill[dq_pkg::OCC_W-1:0];
    return res;
  endfunction

  initial begin
    errors  = 0;
    n_ok    = 0;
    n_full  = 0;
    n_empty = 0;
  end

  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      front_idx = 0;
      back_idx  = 0;
      fill      = 0;
      expected_results.delete();
    end else begin
      // Retire the response first: it always belongs to an earlier request beat.
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          $error("response beat arrived with no request outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_pop_value !== want.pop_value) begin
            $error("pop_value: expected %0d, actual %0d",
                   $signed(want.pop_value), $signed(rsp_pop_value));
            errors++;
          end
          if (rsp_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_status);
            errors++;
          end
          if (rsp_occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, rsp_occupancy);
            errors++;
          end
        end
        case (rsp_status)
          dq_pkg::ST_OK:    n_ok++;
          dq_pkg::ST_FULL:  n_full++;
          dq_pkg::ST_EMPTY: n_empty++;
          default:          ;
        endcase
      end
      if (req_valid && req_ready)
        expected_results.push_back(apply_request(req_action, req_push_value));
    end
    pending     <= expected_results.size();
    fail_count  <= errors;
    ok_count    <= n_ok;
    full_count  <= n_full;
    empty_count <= n_empty;
  end

endmodule

// ===== sim/tb_circular_deque_unit.sv =====
// Top of the circular deque testbench: clock, reset, request and response stimulus, verdict.
// Depends on dq_pkg, dq_if, circular_deque_unit and deque_checker.
module tb_circular_deque_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TOTAL  = 1450;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   ok_count;
  int   full_count;
  int   empty_count;
  int   sent_count;
  int   burst_left;
  int   cycle_count;

  dq_req_if req_bus();
  dq_rsp_if rsp_bus();

  circular_deque_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  deque_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_bus.valid),
    .req_ready      (req_bus.ready),
    .req_action     (req_bus.action),
    .req_push_value (req_bus.push_value),
    .rsp_valid      (rsp_bus.valid),
    .rsp_ready      (rsp_bus.ready),
    .rsp_pop_value  (rsp_bus.pop_value),
    .rsp_status     (rsp_bus.status),
    .rsp_occupancy  (rsp_bus.occupancy),
    .fail_count     (fail_count),
    .pending        (pending),
    .ok_count       (ok_count),
    .full_count     (full_count),
    .empty_count    (empty_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offers one request beat and waits for the edge that accepts it. Bursts end at
  // random, and a gap with valid low may follow before the task returns.
  task automatic send_beat(input dq_pkg::action_t act,
                           input logic [dq_pkg::DATA_W-1:0] val);
    int gap;
    req_bus.valid      <= 1'b1;
    req_bus.action     <= act;
    req_bus.push_value <= val;
    do @(posedge clk); while (!req_bus.ready);
    sent_count++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // The response side cycles through four stall patterns, one of them never stalling.
  initial begin
    int rcv_cycle;
    rcv_cycle = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rcv_cycle++;
      case ((rcv_cycle / 97) % 4)
        0:       rsp_bus.ready <= 1'b1;
        1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
        2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_bus.ready <= ((rcv_cycle % 7) < 4);
      endcase
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped at the cycle limit with %0d responses outstanding.", pending);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int phase_len;
    int push_pct;
    bit is_push;
    bit at_front;
    logic [dq_pkg::DATA_W-1:0] val;
    dq_pkg::action_t act;

    sent_count = 0;
    burst_left = $urandom_range(1, 16);
    rst                <= 1'b1;
    req_bus.valid      <= 1'b0;
    req_bus.action     <= dq_pkg::ACT_PUSH_FRONT;
    req_bus.push_value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Both pops on an empty deque are refused.
    send_beat(dq_pkg::ACT_POP_FRONT, 32'h1234_5678);
    send_beat(dq_pkg::ACT_POP_REAR, 32'hFFFF_FFFF);
    // The first front push wraps the head below slot zero.
    send_beat(dq_pkg::ACT_PUSH_FRONT, 32'h7FFF_FFFF);
    send_beat(dq_pkg::ACT_PUSH_REAR, 32'h8000_0000);
    send_beat(dq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF);
    send_beat(dq_pkg::ACT_PUSH_REAR, 32'h0000_0000);
    for (int i = 0; i < 4; i++)
      send_beat((i % 2 == 0) ? dq_pkg::ACT_PUSH_FRONT : dq_pkg::ACT_PUSH_REAR,
                32'hA5A5_0000 + i);
    // The deque is full now, so pushes at either end are refused.
    send_beat(dq_pkg::ACT_PUSH_FRONT, 32'h5A5A_5A5A);
    send_beat(dq_pkg::ACT_PUSH_REAR, 32'hC3C3_C3C3);
    for (int i = 0; i < 8; i++)
      send_beat((i % 2 == 0) ? dq_pkg::ACT_POP_REAR : dq_pkg::ACT_POP_FRONT, $urandom);
    send_beat(dq_pkg::ACT_POP_REAR, 32'h0000_0001);

    // Random phases lean toward filling, draining or neither, so both full and
    // empty are reached often and the pointers wrap in both directions.
    while (sent_count < ITEM_TOTAL) begin
      phase_len = $urandom_range(8, 48);
      case ($urandom_range(0, 2))
        0:       push_pct = 75;
        1:       push_pct = 25;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < phase_len && sent_count < ITEM_TOTAL; i++) begin
        is_push  = ($urandom_range(0, 99) < push_pct);
        at_front = 1'($urandom_range(0, 1));
        if (is_push)
          act = at_front ? dq_pkg::ACT_PUSH_FRONT : dq_pkg::ACT_PUSH_REAR;
        else
          act = at_front ? dq_pkg::ACT_POP_FRONT : dq_pkg::ACT_POP_REAR;
        case ($urandom_range(0, 11))
          0:       val = 32'h7FFF_FFFF;
          1:       val = 32'h8000_0000;
          2:       val = 32'hFFFF_FFFF;
          3:       val = 32'h0000_0000;
          default: val = $urandom;
        endcase
        send_beat(act, val);
      end
    end
    req_bus.valid <= 1'b0;

    // The checker's outstanding count is a registered copy and may lag the last beat.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d request beats in random bursts against a stalling response side.",
             sent_count);
    $display("Responses seen: %0d ok, %0d refused as full, %0d refused as empty.",
             ok_count, full_count, empty_count);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== circular_deque_unit.f =====
rtl/dq_pkg.sv
rtl/dq_if.sv
rtl/dq_cell.sv
rtl/dq_ctrl.sv
rtl/circular_deque_unit.sv
sim/deque_checker.sv
sim/tb_circular_deque_unit.sv
